// ----- sv/scm_pkg.sv -----
// Shared types, codes and constants of the spectral compressor mask unit.
`timescale 1ns / 1ps
`default_nettype none

package scm_pkg;

	localparam int unsigned VAL_W   = 24;
	localparam int unsigned ROOT_W  = 24;
	localparam int unsigned RAD_W   = 48;
	localparam int unsigned PROD_W  = 56;
	localparam int unsigned STEP_W  = 5;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROOT_W - 1);
	localparam logic [VAL_W-1:0]  VAL_MAX   = '1;

	localparam logic [1:0] OP_GAIN_WR = 2'd0;
	localparam logic [1:0] OP_EQ_WR   = 2'd1;
	localparam logic [1:0] OP_PROCESS = 2'd2;

	localparam logic [1:0] CFG_EQ_ENABLE   = 2'd0;
	localparam logic [1:0] CFG_EQ_GLOBAL   = 2'd1;
	localparam logic [1:0] CFG_METER_DECAY = 2'd2;
	localparam logic [1:0] CFG_DELTA_DECAY = 2'd3;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [10:0]       bin_index;
		logic signed [23:0] bin_real;
		logic signed [23:0] bin_imag;
		logic [23:0]       table_word;
	} in_word_t;

	typedef struct packed {
		logic [23:0] mask_gain;
		logic [23:0] peak_meter;
		logic [23:0] bin_reduction;
	} out_word_t;

	typedef enum logic [4:0] {
		DP_NONE,
		DP_CLEAR,
		DP_LOAD,
		DP_SQ_RE,
		DP_SQ_IM,
		DP_SQRT_INIT,
		DP_SQRT_STEP,
		DP_MUL_TEST,
		DP_DECIDE,
		DP_DIV_STEP,
		DP_MUL_METER,
		DP_UPD_METER,
		DP_UPD_RED,
		DP_EQ_P,
		DP_EQ_MUL,
		DP_EQ_SAT,
		DP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} scm_cmd_t;

	typedef struct packed {
		logic in_proc;
		logic step_last;
		logic need_div;
		logic eq_on;
		logic clear_done;
	} scm_sts_t;

endpackage

`default_nettype wire

// ----- sv/spectral_compressor_mask_unit.sv -----
// Top level of the spectral compressor mask unit.
// The input channel takes one word per FFT bin or table write: opcode, bin
// index, real and imaginary parts and a table value. Gain and equaliser
// table writes give no result, and neither does any word with an unused
// opcode or a bin index of BIN_COUNT or more.
// A process word gives one result word on the output channel: the mask, the
// peak meter level and the bin's held reduction. The square root is
// bit-serial (one root bit a cycle), and so is the reciprocal (one quotient
// bit a cycle), which runs only when it is needed. The equaliser, when on,
// adds its scale, multiply and saturate steps.
// One bin is in work at a time; the next word is taken once the result is
// in the output register, while that result still waits to be taken.
// When the receiver stalls, the result holds and a finished bin waits in
// its last step until the output register is free.
// After reset the reduction store is cleared, one entry a cycle, with input
// stalled until every entry is clear; configuration writes are taken at
// any time. The gain and equaliser tables hold nothing until written.
`timescale 1ns / 1ps
`default_nettype none

module spectral_compressor_mask_unit #(
	parameter int unsigned BIN_COUNT = 1025
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  scm_pkg::in_word_t   in_word,
	output logic                out_valid,
	input  wire                 out_stall,
	output scm_pkg::out_word_t  out_word,
	input  wire                 cfg_we,
	input  wire [1:0]           cfg_index,
	input  wire [23:0]          cfg_data
);
	import scm_pkg::*;

	scm_cmd_t cmd;
	scm_sts_t sts;

	scm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	scm_datapath #(
		.BIN_COUNT (BIN_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_word   (in_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_word  (out_word)
	);

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_EMIT) |-> !(out_valid && out_stall))
		else $error("result word loaded over one still waiting");

	a_busy_after_bin: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && sts.in_proc) |=> in_stall)
		else $error("input taken while a bin is in work");

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_DIV_STEP) |-> ($past(cmd.op) == DP_DIV_STEP || $past(cmd.op) == DP_DECIDE))
		else $error("reciprocal step without a decision");

endmodule

`default_nettype wire

// ----- sv/scm_datapath.sv -----
// Datapath of the mask unit: tables, shared multiplier, root and reciprocal units.
`timescale 1ns / 1ps
`default_nettype none

module scm_datapath #(
	parameter int unsigned BIN_COUNT = 1025
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  scm_pkg::scm_cmd_t     cmd,
	output scm_pkg::scm_sts_t     sts,
	input  scm_pkg::in_word_t     in_word,
	input  wire                   cfg_we,
	input  wire [1:0]             cfg_index,
	input  wire [23:0]            cfg_data,
	output scm_pkg::out_word_t    out_word
);
	import scm_pkg::*;

	localparam int unsigned AW = $clog2(BIN_COUNT);

	logic [VAL_W-1:0] gain_mem [BIN_COUNT];
	logic [VAL_W-1:0] eq_mem   [BIN_COUNT];
	logic [VAL_W-1:0] red_mem  [BIN_COUNT];

	logic             eq_enable_q;
	logic [23:0]      eq_global_q;
	logic [15:0]      meter_decay_q;
	logic [15:0]      delta_decay_q;
	logic [AW-1:0]    clr_cnt_q;
	logic [VAL_W-1:0] meter_q;

	logic [AW-1:0]    idx_q;
	logic [23:0]      are_q;
	logic [23:0]      aim_q;
	logic [VAL_W-1:0] gain_q;
	logic [VAL_W-1:0] eqt_q;
	logic [VAL_W-1:0] held_q;
	logic [PROD_W-1:0] prod_q;
	logic [RAD_W-1:0] acc_q;
	logic [RAD_W-1:0] rad_q;
	logic [25:0]      rem_q;
	logic [ROOT_W-1:0] mag_q;
	logic [24:0]      drem_q;
	logic [STEP_W-1:0] cnt_q;
	logic [VAL_W-1:0] mask_q;
	logic [VAL_W-1:0] cand_q;
	logic [VAL_W-1:0] red_out_q;
	logic [31:0]      p_q;
	out_word_t        out_q;

	logic              in_range;
	logic [23:0]       in_are;
	logic [23:0]       in_aim;
	logic [31:0]       mul_a;
	logic [23:0]       mul_b;
	logic [PROD_W-1:0] mul_p;
	logic [27:0]       sq_sh;
	logic [27:0]       sq_trial;
	logic [24:0]       dv_sh;
	logic [24:0]       dv_mag;
	logic              big;
	logic [VAL_W-1:0]  red_new;
	logic [VAL_W-1:0]  red_cur;
	logic [VAL_W-1:0]  held_dec;

	assign in_range = 32'(in_word.bin_index) < BIN_COUNT;
	assign in_are   = in_word.bin_real[23] ? 24'(~in_word.bin_real + 24'd1) : in_word.bin_real;
	assign in_aim   = in_word.bin_imag[23] ? 24'(~in_word.bin_imag + 24'd1) : in_word.bin_imag;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			DP_SQ_RE: begin
				mul_a = 32'(are_q);
				mul_b = are_q;
			end
			DP_SQ_IM: begin
				mul_a = 32'(aim_q);
				mul_b = aim_q;
			end
			DP_MUL_TEST: begin
				mul_a = 32'(gain_q);
				mul_b = mag_q;
			end
			DP_MUL_METER: begin
				mul_a = 32'(meter_q);
				mul_b = 24'(meter_decay_q);
			end
			DP_UPD_METER: begin
				mul_a = 32'(held_q);
				mul_b = 24'(delta_decay_q);
			end
			DP_UPD_RED: begin
				mul_a = 32'(mask_q);
				mul_b = eq_global_q;
			end
			DP_EQ_MUL: begin
				mul_a = p_q;
				mul_b = eqt_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign sq_sh    = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
	assign sq_trial = {2'b00, mag_q, 2'b01};
	assign dv_sh    = {drem_q[23:0], 1'b0};
	assign dv_mag   = {1'b0, mag_q};
	assign big      = (prod_q[47:0] > 48'h1_0000_0000) && (mag_q != '0);
	assign red_cur  = (gain_q > mask_q) ? gain_q - mask_q : '0;
	assign held_dec = prod_q[39:16];
	assign red_new  = (red_cur > held_q) ? red_cur : held_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_enable_q   <= 1'b0;
			eq_global_q   <= 24'd65536;
			meter_decay_q <= 16'd65000;
			delta_decay_q <= 16'd60000;
			clr_cnt_q     <= '0;
			meter_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_EQ_ENABLE:   eq_enable_q   <= cfg_data[0];
					CFG_EQ_GLOBAL:   eq_global_q   <= cfg_data;
					CFG_METER_DECAY: meter_decay_q <= cfg_data[15:0];
					CFG_DELTA_DECAY: delta_decay_q <= cfg_data[15:0];
					default:         eq_enable_q   <= eq_enable_q;
				endcase
			end
			if (cmd.op == DP_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cmd.op == DP_UPD_METER) begin
				meter_q <= (cand_q > meter_q) ? cand_q : prod_q[39:16];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_LOAD && in_range && in_word.opcode == OP_GAIN_WR) begin
			gain_mem[AW'(in_word.bin_index)] <= in_word.table_word;
		end
		if (cmd.op == DP_SQ_RE) begin
			gain_q <= gain_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_LOAD && in_range && in_word.opcode == OP_EQ_WR) begin
			eq_mem[AW'(in_word.bin_index)] <= in_word.table_word;
		end
		if (cmd.op == DP_SQ_RE) begin
			eqt_q <= eq_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_CLEAR) begin
			red_mem[clr_cnt_q] <= '0;
		end else if (cmd.op == DP_UPD_RED) begin
			red_mem[idx_q] <= red_new;
		end
		if (cmd.op == DP_SQ_RE) begin
			held_q <= red_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				idx_q <= AW'(in_word.bin_index);
				are_q <= in_are;
				aim_q <= in_aim;
			end
			DP_SQ_RE: begin
				prod_q <= mul_p;
			end
			DP_SQ_IM: begin
				acc_q  <= prod_q[RAD_W-1:0];
				prod_q <= mul_p;
			end
			DP_SQRT_INIT: begin
				rad_q <= acc_q + prod_q[RAD_W-1:0];
				rem_q <= '0;
				mag_q <= '0;
				cnt_q <= '0;
			end
			DP_SQRT_STEP: begin
				if (sq_sh >= sq_trial) begin
					rem_q <= 26'(sq_sh - sq_trial);
					mag_q <= {mag_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q <= 26'(sq_sh);
					mag_q <= {mag_q[ROOT_W-2:0], 1'b0};
				end
				rad_q <= {rad_q[RAD_W-3:0], 2'b00};
				cnt_q <= cnt_q + STEP_W'(1);
			end
			DP_MUL_TEST: begin
				prod_q <= mul_p;
			end
			DP_DECIDE: begin
				cand_q <= (prod_q[47:40] != '0) ? VAL_MAX : prod_q[39:16];
				drem_q <= 25'd256;
				cnt_q  <= '0;
				if (big) begin
					mask_q <= VAL_MAX;
				end else begin
					mask_q <= gain_q;
				end
			end
			DP_DIV_STEP: begin
				if (dv_sh >= dv_mag) begin
					drem_q <= dv_sh - dv_mag;
					mask_q <= {mask_q[VAL_W-2:0], 1'b1};
				end else begin
					drem_q <= dv_sh;
					mask_q <= {mask_q[VAL_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + STEP_W'(1);
			end
			DP_MUL_METER: begin
				prod_q <= mul_p;
			end
			DP_UPD_METER: begin
				prod_q <= mul_p;
			end
			DP_UPD_RED: begin
				red_out_q <= red_new;
				prod_q    <= mul_p;
			end
			DP_EQ_P: begin
				p_q <= prod_q[47:16];
			end
			DP_EQ_MUL: begin
				prod_q <= mul_p;
			end
			DP_EQ_SAT: begin
				mask_q <= (prod_q[55:40] != '0) ? VAL_MAX : prod_q[39:16];
			end
			DP_EMIT: begin
				out_q.mask_gain     <= mask_q;
				out_q.peak_meter    <= meter_q;
				out_q.bin_reduction <= red_out_q;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign sts.in_proc    = in_range && (in_word.opcode == OP_PROCESS);
	assign sts.step_last  = (cnt_q == STEP_LAST);
	assign sts.need_div   = big && (mag_q > 24'd256);
	assign sts.eq_on      = eq_enable_q;
	assign sts.clear_done = (clr_cnt_q == AW'(BIN_COUNT - 1));
	assign out_word       = out_q;

endmodule

`default_nettype wire

// ----- sv/scm_ctrl.sv -----
// Controller state machine that sequences the mask unit datapath.
`timescale 1ns / 1ps
`default_nettype none

module scm_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  wire               out_stall,
	input  scm_pkg::scm_sts_t sts,
	output scm_pkg::scm_cmd_t cmd
);
	import scm_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_MUL_TEST,
		ST_DECIDE,
		ST_DIV,
		ST_MUL_METER,
		ST_UPD_METER,
		ST_UPD_RED,
		ST_EQ_P,
		ST_EQ_MUL,
		ST_EQ_SAT,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		cmd.op = DP_NONE;
		case (state_q)
			ST_CLEAR:     cmd.op = DP_CLEAR;
			ST_IDLE:      cmd.op = in_valid ? DP_LOAD : DP_NONE;
			ST_SQ_RE:     cmd.op = DP_SQ_RE;
			ST_SQ_IM:     cmd.op = DP_SQ_IM;
			ST_SQRT_INIT: cmd.op = DP_SQRT_INIT;
			ST_SQRT:      cmd.op = DP_SQRT_STEP;
			ST_MUL_TEST:  cmd.op = DP_MUL_TEST;
			ST_DECIDE:    cmd.op = DP_DECIDE;
			ST_DIV:       cmd.op = DP_DIV_STEP;
			ST_MUL_METER: cmd.op = DP_MUL_METER;
			ST_UPD_METER: cmd.op = DP_UPD_METER;
			ST_UPD_RED:   cmd.op = DP_UPD_RED;
			ST_EQ_P:      cmd.op = DP_EQ_P;
			ST_EQ_MUL:    cmd.op = DP_EQ_MUL;
			ST_EQ_SAT:    cmd.op = DP_EQ_SAT;
			ST_EMIT:      cmd.op = out_free ? DP_EMIT : DP_NONE;
			default:      cmd.op = DP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			out_valid <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sts.clear_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid && sts.in_proc) begin
						state_q <= ST_SQ_RE;
					end
				end
				ST_SQ_RE:     state_q <= ST_SQ_IM;
				ST_SQ_IM:     state_q <= ST_SQRT_INIT;
				ST_SQRT_INIT: state_q <= ST_SQRT;
				ST_SQRT: begin
					if (sts.step_last) begin
						state_q <= ST_MUL_TEST;
					end
				end
				ST_MUL_TEST:  state_q <= ST_DECIDE;
				ST_DECIDE: begin
					state_q <= sts.need_div ? ST_DIV : ST_MUL_METER;
				end
				ST_DIV: begin
					if (sts.step_last) begin
						state_q <= ST_MUL_METER;
					end
				end
				ST_MUL_METER: state_q <= ST_UPD_METER;
				ST_UPD_METER: state_q <= ST_UPD_RED;
				ST_UPD_RED: begin
					state_q <= sts.eq_on ? ST_EQ_P : ST_EMIT;
				end
				ST_EQ_P:      state_q <= ST_EQ_MUL;
				ST_EQ_MUL:    state_q <= ST_EQ_SAT;
				ST_EQ_SAT:    state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
